/* hw/rtl/tep_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_pkg: shared types and constants of the TLV event record parser
// Status codes, tag codes, the offset width and the result word layout.
// ----------------------------------------------------------------------------
package tep_pkg;

    localparam int OFFSET_BITS = 20;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_SHORT       = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_CUT_HEADER  = 3'd3;
    localparam logic [2:0] ST_ZERO_BLOB   = 3'd4;
    localparam logic [2:0] ST_BAD_TAG     = 3'd5;
    localparam logic [2:0] ST_TRUNCATED   = 3'd6;
    localparam logic [2:0] ST_OVERFLOW    = 3'd7;

    localparam logic [1:0] TAG_BLOB  = 2'b00;
    localparam logic [1:0] TAG_INT32 = 2'b01;
    localparam logic [1:0] TAG_BAD   = 2'b10;
    localparam logic [1:0] TAG_FLOAT = 2'b11;

    localparam logic KIND_DESC   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // results caused by one byte: an optional descriptor, then an optional status
    typedef struct packed {
        logic                   desc_vld;
        logic                   stat_vld;
        logic [13:0]            rec_id;
        logic [1:0]             tag;
        logic [15:0]            size_raw;
        logic [17:0]            body_len;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [2:0]             status;
    } t_result;

endpackage

/* hw/rtl/tlv_event_record_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_event_record_parser: streaming parser for big-endian TLV record buffers
// Checks the version word, walks the record headers, skips payloads and
// reports a descriptor per record and a status at the end of each buffer.
//
//   channel  direction  handshake                word
//   input    in         i_in_valid/o_in_ready    data_byte, last_byte
//   output   out        o_out_valid/i_out_ready  one descriptor or status
//   config   in         psel/penable/pwrite      expected_version at 0x0
//
// One byte is taken per cycle while the queue has room; its results appear in the queue the next cycle.
// A byte that ends a record and the buffer gives two output words, sent one
// after the other from the two-entry result queue; input stalls only when it is full.
// Reset (synchronous, active low) starts a new buffer and sets the version to 2.
// ----------------------------------------------------------------------------
module tlv_event_record_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_kind,
    output logic [13:0]                     o_rec_id,
    output logic [1:0]                      o_tag,
    output logic [15:0]                     o_size_raw,
    output logic [17:0]                     o_body_len,
    output logic [tep_pkg::OFFSET_BITS-1:0] o_payload_offset,
    output logic [2:0]                      o_status,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic signed [31:0] r_version;
    logic               accept;
    logic               cfg_wr;
    tep_pkg::t_result   step_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == 1'b0) ? r_version : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version <= 32'sd2;
        end else if (cfg_wr && paddr[2] == 1'b0) begin
            r_version <= pwdata;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    tep_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_version   ($unsigned(r_version)),
        .o_res       (step_res)
    );

    tep_outq u_outq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (accept && (step_res.desc_vld || step_res.stat_vld)),
        .i_res            (step_res),
        .o_room           (o_in_ready),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_rec_id         (o_rec_id),
        .o_tag            (o_tag),
        .o_size_raw       (o_size_raw),
        .o_body_len       (o_body_len),
        .o_payload_offset (o_payload_offset),
        .o_status         (o_status)
    );

endmodule

/* hw/rtl/tep_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_core: byte-level parse state of the TLV event record parser
// Updates the version/header shifter, payload counter and offset for each
// accepted byte and reports the descriptor and status that the byte causes.
// ----------------------------------------------------------------------------
module tep_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  logic [31:0]         i_version,
    output tep_pkg::t_result    o_res
);

    localparam logic [1:0] PH_VERSION = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    logic [1:0]                      r_phase, n_phase;
    logic [1:0]                      r_biw, n_biw;
    logic [31:0]                     r_shift, n_shift;
    logic [17:0]                     r_remain, n_remain;
    logic [tep_pkg::OFFSET_BITS-1:0] r_offset, n_offset;
    logic [13:0]                     r_held_fid, n_held_fid;
    logic [1:0]                      r_held_tag, n_held_tag;
    logic [15:0]                     r_held_size, n_held_size;
    logic [17:0]                     r_held_len, n_held_len;
    logic [tep_pkg::OFFSET_BITS-1:0] r_held_start, n_held_start;
    logic [2:0]                      r_err, n_err;

    logic [31:0] word;
    logic [15:0] hdr_size;
    logic [1:0]  hdr_tag;
    logic [17:0] hdr_len;
    logic        desc_vld;
    logic [2:0]  end_status;

    assign word     = {r_shift[23:0], i_data_byte};
    assign hdr_size = word[31:16];
    assign hdr_tag  = word[15:14];

    always_comb begin
        unique case (hdr_tag)
            tep_pkg::TAG_BLOB:  hdr_len = (hdr_size == 16'd1) ? 18'd8 : {2'b00, hdr_size};
            tep_pkg::TAG_INT32: hdr_len = {hdr_size, 2'b00};
            tep_pkg::TAG_FLOAT: hdr_len = {hdr_size, 2'b00};
            default:            hdr_len = '0;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_biw        = r_biw;
        n_shift      = r_shift;
        n_remain     = r_remain;
        n_offset     = r_offset;
        n_held_fid   = r_held_fid;
        n_held_tag   = r_held_tag;
        n_held_size  = r_held_size;
        n_held_len   = r_held_len;
        n_held_start = r_held_start;
        n_err        = r_err;
        desc_vld     = 1'b0;
        end_status   = tep_pkg::ST_OK;

        if (r_phase != PH_ERROR) begin
            if (r_offset == tep_pkg::OFFSET_MAX) begin
                n_phase = PH_ERROR;
                n_err   = tep_pkg::ST_OVERFLOW;
            end else if (r_phase == PH_VERSION || r_phase == PH_HEADER) begin
                n_shift = word;
                n_biw   = r_biw + 2'd1;
                if (r_biw == 2'd3) begin
                    if (r_phase == PH_VERSION) begin
                        if (word != i_version) begin
                            n_phase = PH_ERROR;
                            n_err   = tep_pkg::ST_BAD_VERSION;
                        end else begin
                            n_phase = PH_HEADER;
                        end
                    end else if (hdr_tag == tep_pkg::TAG_BAD) begin
                        n_phase = PH_ERROR;
                        n_err   = tep_pkg::ST_BAD_TAG;
                    end else if (hdr_tag == tep_pkg::TAG_BLOB && hdr_size == 16'd0) begin
                        n_phase = PH_ERROR;
                        n_err   = tep_pkg::ST_ZERO_BLOB;
                    end else begin
                        n_held_fid   = word[13:0];
                        n_held_tag   = hdr_tag;
                        n_held_size  = hdr_size;
                        n_held_len   = hdr_len;
                        n_held_start = r_offset + tep_pkg::OFFSET_ONE;
                        // empty payload completes the record right here
                        if (hdr_len == 18'd0) begin
                            desc_vld = 1'b1;
                        end else begin
                            n_remain = hdr_len;
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
            end else begin
                n_remain = r_remain - 18'd1;
                if (n_remain == 18'd0) begin
                    desc_vld = 1'b1;
                    n_phase  = PH_HEADER;
                    n_biw    = 2'd0;
                end
            end
            n_offset = r_offset + tep_pkg::OFFSET_ONE;
        end

        priority if (n_phase == PH_ERROR)   end_status = n_err;
        else if (n_phase == PH_VERSION)     end_status = tep_pkg::ST_SHORT;
        else if (n_phase == PH_PAYLOAD)     end_status = tep_pkg::ST_TRUNCATED;
        else if (n_biw != 2'd0)             end_status = tep_pkg::ST_CUT_HEADER;
        else                                end_status = tep_pkg::ST_OK;

        // last byte: start a fresh buffer
        if (i_last_byte) begin
            n_phase  = PH_VERSION;
            n_biw    = 2'd0;
            n_offset = '0;
            n_err    = tep_pkg::ST_OK;
        end
    end

    always_comb begin
        o_res.desc_vld       = desc_vld;
        o_res.stat_vld       = i_last_byte;
        o_res.rec_id         = n_held_fid;
        o_res.tag            = n_held_tag;
        o_res.size_raw       = n_held_size;
        o_res.body_len       = n_held_len;
        o_res.payload_offset = n_held_start;
        o_res.status         = end_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_VERSION;
            r_biw    <= 2'd0;
            r_offset <= '0;
            r_err    <= tep_pkg::ST_OK;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_biw    <= n_biw;
            r_offset <= n_offset;
            r_err    <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_shift      <= n_shift;
            r_remain     <= n_remain;
            r_held_fid   <= n_held_fid;
            r_held_tag   <= n_held_tag;
            r_held_size  <= n_held_size;
            r_held_len   <= n_held_len;
            r_held_start <= n_held_start;
        end
    end

endmodule

/* hw/rtl/tep_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_outq: two-entry result queue of the TLV event record parser
// Holds the results of one byte per entry; an entry carrying both a
// descriptor and a status sends the descriptor word first.
// ----------------------------------------------------------------------------
module tep_outq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  tep_pkg::t_result                  i_res,
    output logic                              o_room,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_kind,
    output logic [13:0]                       o_rec_id,
    output logic [1:0]                        o_tag,
    output logic [15:0]                       o_size_raw,
    output logic [17:0]                       o_body_len,
    output logic [tep_pkg::OFFSET_BITS-1:0]   o_payload_offset,
    output logic [2:0]                        o_status
);

    tep_pkg::t_result r_mem [2];
    logic             r_wptr, r_rptr;
    logic             r_half;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    tep_pkg::t_result head;
    logic             head_desc;
    logic             pop, split, retire;

    assign head        = r_mem[r_rptr];
    // descriptor of the head entry still to send, unless r_half shows it already sent and only its status is left
    assign head_desc   = head.desc_vld && !r_half;
    assign o_out_valid = (r_count != 2'd0);
    assign o_room      = (r_count != 2'd2);
    assign pop         = o_out_valid && i_out_ready;
    // descriptor leaves first; the status stays in the entry
    assign split       = head_desc && head.stat_vld;
    assign retire      = pop && !split;

    always_comb begin
        n_count = r_count;
        if (i_push && !retire) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && retire) begin
            n_count = r_count - 2'd1;
        end
    end

    always_comb begin
        if (head_desc) begin
            o_kind           = tep_pkg::KIND_DESC;
            o_rec_id         = head.rec_id;
            o_tag            = head.tag;
            o_size_raw       = head.size_raw;
            o_body_len       = head.body_len;
            o_payload_offset = head.payload_offset;
            o_status         = tep_pkg::ST_OK;
        end else begin
            o_kind           = tep_pkg::KIND_STATUS;
            o_rec_id         = '0;
            o_tag            = '0;
            o_size_raw       = '0;
            o_body_len       = '0;
            o_payload_offset = '0;
            o_status         = head.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_half  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (retire) begin
                r_rptr <= ~r_rptr;
                r_half <= 1'b0;
            end else if (pop && split) begin
                r_half <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_res;
        end
    end

endmodule

/* hw/rtl/tep_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_checker: port-level checks of the TLV event record parser
// Watches the result channel and the input stall; bound to the top level.
// ----------------------------------------------------------------------------
module tep_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_kind,
    input logic [13:0]                     o_rec_id,
    input logic [1:0]                      o_tag,
    input logic [15:0]                     o_size_raw,
    input logic [17:0]                     o_body_len,
    input logic [tep_pkg::OFFSET_BITS-1:0] o_payload_offset,
    input logic [2:0]                      o_status
);

    // a pending word stays valid, with kind and status stable, until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_kind)
            && $stable(o_status)))
        else $error("result word dropped or changed while stalled");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == tep_pkg::KIND_STATUS) |->
            (o_rec_id == '0 && o_tag == '0 && o_size_raw == '0
             && o_body_len == '0 && o_payload_offset == '0))
        else $error("status word carries record fields");

    a_desc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == tep_pkg::KIND_DESC) |->
            (o_status == tep_pkg::ST_OK && o_tag != tep_pkg::TAG_BAD))
        else $error("descriptor with status or bad tag");

    // input stalls only after a byte filled the queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && o_in_ready))
        else $error("input stalled without a new byte");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("queue not empty after reset");

endmodule

bind tlv_event_record_parser tep_checker u_tep_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_kind           (o_kind),
    .o_rec_id         (o_rec_id),
    .o_tag            (o_tag),
    .o_size_raw       (o_size_raw),
    .o_body_len       (o_body_len),
    .o_payload_offset (o_payload_offset),
    .o_status         (o_status)
);
